>>> design/grid_maze_reachability_core_defines.svh
// Assertion macros shared by the maze reachability RTL.
`ifndef GRID_MAZE_REACHABILITY_CORE_DEFINES_SVH
`define GRID_MAZE_REACHABILITY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define GMR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmr assertion failed");
// next-cycle implication, disabled in reset
`define GMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmr assertion failed");
`else
`define GMR_ASSERT_NOW(label, ante, cons)
`define GMR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/gmr_pkg.sv
// Types and constants for the maze reachability core.
`default_nettype none
package gmr_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control broadcast from the sequencer to every row cell
  typedef struct packed {
    logic       wr;
    logic       seed;
    logic       step;
    logic       wall;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] trow;
    logic [3:0] tcol;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/grid_maze_reachability_core.sv
// Top level: command port, flood sequencer and the chain of row cells.
//
//  channel   signals                                   handshake
//  command   op row col is_wall target_row target_col  start & !busy
//  result    path_found                                done (one cycle)
//
// A write takes effect at the accepting edge; busy stays low, no result.
// A solve seeds the flood at the accepting edge, then spreads one cell per
// cycle in every direction through the row cells. busy holds until the
// target is reached or the flood stops growing. done pulses in the cycle
// busy drops.
// rst clears the wall map to all open. Results cannot be stalled.
`default_nettype none
`include "grid_maze_reachability_core_defines.svh"
module grid_maze_reachability_core #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire        op,
  input  wire  [3:0] row,
  input  wire  [3:0] col,
  input  wire        is_wall,
  input  wire  [3:0] target_row,
  input  wire  [3:0] target_col,
  output logic       done,
  output logic       path_found
);

  gmr_pkg::state_t    state;
  gmr_pkg::state_t    state_next;
  gmr_pkg::cell_ctl_t ctl;

  logic [3:0] trow;
  logic [3:0] tcol;
  logic       accept;
  logic       finish;
  logic       step;
  logic       tgt_any;
  logic       chg_any;

  logic [GRID_ROWS-1:0][GRID_COLS-1:0] reached_rows;
  logic [GRID_ROWS-1:0]                changed_rows;
  logic [GRID_ROWS-1:0]                tgt_rows;

  assign accept  = start && !busy;
  assign tgt_any = |tgt_rows;
  assign chg_any = |changed_rows;
  assign finish  = tgt_any || !chg_any;

  always_comb begin
    state_next = state;
    case (state)
      gmr_pkg::ST_IDLE: begin
        if (accept && op == gmr_pkg::OP_SOLVE) state_next = gmr_pkg::ST_RUN;
      end
      gmr_pkg::ST_RUN: begin
        if (finish) state_next = gmr_pkg::ST_IDLE;
      end
      default: state_next = gmr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    step = 1'b0;
    case (state)
      gmr_pkg::ST_IDLE: begin
        busy = 1'b0;
        step = 1'b0;
      end
      gmr_pkg::ST_RUN: begin
        busy = 1'b1;
        step = !finish;
      end
      default: begin
        busy = 1'b0;
        step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gmr_pkg::ST_IDLE;
      done       <= 1'b0;
      path_found <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == gmr_pkg::ST_RUN) && finish;
      if ((state == gmr_pkg::ST_RUN) && finish) path_found <= tgt_any;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == gmr_pkg::OP_SOLVE) begin
      trow <= target_row;
      tcol <= target_col;
    end
  end

  always_comb begin
    ctl      = '0;
    ctl.wr   = accept && (op == gmr_pkg::OP_WRITE);
    ctl.seed = accept && (op == gmr_pkg::OP_SOLVE);
    ctl.step = step;
    ctl.wall = is_wall;
    ctl.row  = row;
    ctl.col  = col;
    ctl.trow = trow;
    ctl.tcol = tcol;
  end

  for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
    logic [GRID_COLS-1:0] up_vec;
    logic [GRID_COLS-1:0] dn_vec;
    if (r == 0) begin : g_top
      assign up_vec = '0;
    end else begin : g_mid_up
      assign up_vec = reached_rows[r-1];
    end
    if (r == GRID_ROWS - 1) begin : g_bot
      assign dn_vec = '0;
    end else begin : g_mid_dn
      assign dn_vec = reached_rows[r+1];
    end
    gmr_cell #(
      .ROW_IDX (r),
      .COLS    (GRID_COLS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .up_reached (up_vec),
      .dn_reached (dn_vec),
      .reached    (reached_rows[r]),
      .changed    (changed_rows[r]),
      .tgt_hit    (tgt_rows[r])
    );
  end

  `GMR_ASSERT_NOW(a_done_not_busy, done, !busy)
  `GMR_ASSERT_NEXT(a_solve_goes_busy, accept && op == gmr_pkg::OP_SOLVE, busy)
  `GMR_ASSERT_NEXT(a_write_stays_idle, accept && op == gmr_pkg::OP_WRITE, !busy && !done)
  `GMR_ASSERT_NEXT(a_done_single, done, !done)

endmodule
`default_nettype wire

>>> design/gmr_cell.sv
// One grid row: wall bits, reached bits and the per-step flood update.
`default_nettype none
`include "grid_maze_reachability_core_defines.svh"
module gmr_cell #(
  parameter int ROW_IDX = 0,
  parameter int COLS    = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire gmr_pkg::cell_ctl_t ctl,
  input  wire  [COLS-1:0]      up_reached,
  input  wire  [COLS-1:0]      dn_reached,
  output logic [COLS-1:0]      reached,
  output logic                 changed,
  output logic                 tgt_hit
);

  logic [COLS-1:0] wall;
  logic [COLS-1:0] reached_next;
  logic [COLS-1:0] col_hit;
  logic [COLS-1:0] tcol_hit;
  logic [COLS-1:0] spread;
  logic            row_hit;
  logic            trow_hit;

  assign row_hit  = (int'(ctl.row) == ROW_IDX);
  assign trow_hit = (int'(ctl.trow) == ROW_IDX);

  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      col_hit[j]  = (int'(ctl.col) == j);
      tcol_hit[j] = (int'(ctl.tcol) == j);
    end
  end

  // neighbors: left, right, row above, row below
  assign spread       = {reached[COLS-2:0], 1'b0} | {1'b0, reached[COLS-1:1]}
                      | up_reached | dn_reached;
  assign reached_next = reached | (~wall & spread);
  assign tgt_hit      = trow_hit & (|(reached & tcol_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      wall    <= '0;
      reached <= '0;
      changed <= 1'b0;
    end else begin
      if (ctl.wr && row_hit) begin
        for (int j = 0; j < COLS; j++) begin
          if (col_hit[j]) wall[j] <= ctl.wall;
        end
      end
      if (ctl.seed) begin
        // start cell is entered whatever its wall bit
        reached <= row_hit ? col_hit : '0;
        changed <= 1'b1;
      end else if (ctl.step) begin
        reached <= reached_next;
        changed <= (reached_next != reached);
      end
    end
  end

  `GMR_ASSERT_NEXT(a_reached_monotonic, ctl.step && !ctl.seed, (reached & $past(reached)) == $past(reached))
  `GMR_ASSERT_NEXT(a_seed_flags_change, ctl.seed, changed)
  `GMR_ASSERT_NEXT(a_idle_holds_reached, !ctl.seed && !ctl.step, reached == $past(reached))

endmodule
`default_nettype wire

>>> bench/grid_maze_reachability_core_test.sv
// Self-checking bench for the maze reachability core: directed mazes, then random maze traffic.
module grid_maze_reachability_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS  = 16;
  localparam int COLS  = 16;
  localparam int CELLS = ROWS * COLS;

  typedef struct {
    logic       op;
    logic [3:0] row;
    logic [3:0] col;
    logic       is_wall;
    logic [3:0] trow;
    logic [3:0] tcol;
  } maze_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       op = gmr_pkg::OP_WRITE;
  logic [3:0] row = '0;
  logic [3:0] col = '0;
  logic       is_wall = 1'b0;
  logic [3:0] target_row = '0;
  logic [3:0] target_col = '0;
  logic       busy;
  logic       done;
  logic       path_found;

  grid_maze_reachability_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .row       (row),
    .col       (col),
    .is_wall   (is_wall),
    .target_row(target_row),
    .target_col(target_col),
    .done      (done),
    .path_found(path_found)
  );

  always #5 clk = ~clk;

  // bench copy of the wall map and the answers still owed by the block
  bit maze_walls [CELLS];
  bit expected_reach [$];
  int gap_pct = 17;
  int errors = 0;
  int writes_sent = 0;
  int solves_checked = 0;
  int reached_count = 0;

  // breadth-first flood over the bench wall map
  function automatic bit flood_reaches(input logic [3:0] sr, input logic [3:0] sc,
                                       input logic [3:0] tr, input logic [3:0] tc);
    bit seen [CELLS];
    int frontier [$];
    int cur, r, c, nr, nc;
    int step_r [4] = '{0, 1, 0, -1};
    int step_c [4] = '{1, 0, -1, 0};
    foreach (seen[i]) seen[i] = 1'b0;
    if (sr >= ROWS || sc >= COLS) return 1'b0;
    seen[sr * COLS + sc] = 1'b1;
    frontier.push_back(sr * COLS + sc);
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      r = cur / COLS;
      c = cur % COLS;
      if (r == tr && c == tc) return 1'b1;
      for (int k = 0; k < 4; k++) begin
        nr = r + step_r[k];
        nc = c + step_c[k];
        // off-grid neighbors behave as walls
        if (nr >= 0 && nc >= 0 && nr < ROWS && nc < COLS) begin
          if (!maze_walls[nr * COLS + nc] && !seen[nr * COLS + nc]) begin
            seen[nr * COLS + nc] = 1'b1;
            frontier.push_back(nr * COLS + nc);
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // one command beat; start is left high so back-to-back beats need no toggle
  task automatic send_beat(input maze_cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= c.op;
    row        <= c.row;
    col        <= c.col;
    is_wall    <= c.is_wall;
    target_row <= c.trow;
    target_col <= c.tcol;
    do @(posedge clk); while (busy);
    if (c.op == gmr_pkg::OP_WRITE) begin
      if (c.row < ROWS && c.col < COLS) maze_walls[c.row * COLS + c.col] = c.is_wall;
      writes_sent++;
    end else begin
      expected_reach.push_back(flood_reaches(c.row, c.col, c.trow, c.tcol));
    end
  endtask

  task automatic write_cell(input int r, input int c, input bit w);
    maze_cmd_t m;
    m.op = gmr_pkg::OP_WRITE;
    m.row = r[3:0];
    m.col = c[3:0];
    m.is_wall = w;
    m.trow = 4'($urandom_range(15));
    m.tcol = 4'($urandom_range(15));
    send_beat(m);
  endtask

  task automatic solve_cells(input int sr, input int sc, input int tr, input int tc);
    maze_cmd_t m;
    m.op = gmr_pkg::OP_SOLVE;
    m.row = sr[3:0];
    m.col = sc[3:0];
    m.is_wall = 1'($urandom_range(1));
    m.trow = tr[3:0];
    m.tcol = tc[3:0];
    send_beat(m);
  endtask

  // drop start and hold off until every owed answer is in
  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_reach.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_grid();
    solve_cells(0, 0, 15, 15);
    solve_cells(15, 15, 0, 0);
  endtask

  task automatic test_start_equals_target();
    solve_cells(7, 9, 7, 9);
  endtask

  task automatic test_start_on_wall();
    write_cell(0, 0, 1'b1);
    solve_cells(0, 0, 0, 15);
    solve_cells(0, 0, 0, 0);
  endtask

  task automatic test_target_on_wall();
    write_cell(15, 0, 1'b1);
    solve_cells(0, 0, 15, 0);
  endtask

  // sealed corner: the flood must not wrap across row ends
  task automatic test_grid_edges();
    write_cell(15, 14, 1'b1);
    write_cell(14, 15, 1'b1);
    solve_cells(15, 15, 0, 0);
    solve_cells(0, 15, 15, 15);
  endtask

  task automatic test_enclosed_start();
    write_cell(4, 5, 1'b1);
    write_cell(6, 5, 1'b1);
    write_cell(5, 4, 1'b1);
    write_cell(5, 6, 1'b1);
    solve_cells(5, 5, 0, 0);
    write_cell(5, 6, 1'b0);
    solve_cells(5, 5, 0, 0);
  endtask

  function automatic int pick_edge_or_any();
    return ($urandom_range(99) < 20) ? 15 * $urandom_range(1) : $urandom_range(15);
  endfunction

  task automatic solve_random();
    int sr, sc, tr, tc, pick;
    sr = pick_edge_or_any();
    sc = pick_edge_or_any();
    pick = $urandom_range(99);
    if (pick < 20) begin
      tr = sr;
      tc = sc;
    end else if (pick < 45) begin
      tr = sr + $urandom_range(2) - 1;
      tc = sc + $urandom_range(2) - 1;
    end else begin
      tr = pick_edge_or_any();
      tc = pick_edge_or_any();
    end
    solve_cells(sr, sc, tr, tc);
  endtask

  task automatic test_random_mazes(input int pct, input int budget);
    int sent, pick, batch, density, n, r, c;
    maze_cmd_t m;
    gap_pct = pct;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // grow the maze a little, then ask a few questions about it
        density = ($urandom_range(2) == 0) ? 20 : (($urandom_range(1) == 0) ? 35 : 55);
        batch = $urandom_range(3, 12);
        repeat (batch)
          write_cell($urandom_range(15), $urandom_range(15), $urandom_range(99) < density);
        n = $urandom_range(1, 4);
        repeat (n) solve_random();
        sent += batch + n;
      end else if (pick < 93) begin
        m.op = 1'($urandom_range(1));
        m.row = 4'($urandom_range(15));
        m.col = 4'($urandom_range(15));
        m.is_wall = 1'($urandom_range(1));
        m.trow = 4'($urandom_range(15));
        m.tcol = 4'($urandom_range(15));
        send_beat(m);
        sent++;
      end else begin
        // start from a fresh wall, target possibly walled too
        r = pick_edge_or_any();
        c = pick_edge_or_any();
        write_cell(r, c, 1'b1);
        solve_cells(r, c, $urandom_range(15), $urandom_range(15));
        sent += 2;
      end
      if ($urandom_range(24) == 0) pause_until_drained();
    end
    pause_until_drained();
  endtask

  // result checker: whenever done is high, path_found is compared with the oldest owed answer
  always @(posedge clk) begin : check_results
    bit want;
    if (!rst && done) begin
      if (expected_reach.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual path_found=%0b",
                 $time, path_found);
      end else begin
        want = expected_reach.pop_front();
        solves_checked++;
        if (want) reached_count++;
        if (path_found !== want) begin
          errors++;
          $display("%0t: path_found mismatch, expected %0b actual %0b", $time, want, path_found);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 17;
    test_empty_grid();
    test_start_equals_target();
    test_start_on_wall();
    test_target_on_wall();
    test_grid_edges();
    test_enclosed_start();
    pause_until_drained();
    test_random_mazes(17, 190);
    test_random_mazes(73, 190);
    test_random_mazes(0, 190);
    repeat (20) @(posedge clk);
    $display("covered %0d cell writes and %0d solves (%0d reachable, %0d blocked)",
             writes_sent, solves_checked, reached_count, solves_checked - reached_count);
    $display("directed corners, walled start and target, sealed cells, then random mazes");
    if (errors == 0) begin
      $display("[grid_maze_reachability_core] OK");
    end else begin
      $display("[grid_maze_reachability_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d answers outstanding", expected_reach.size());
    $display("[grid_maze_reachability_core] ERROR");
    $finish;
  end

endmodule
